@@ rtl/blsu_pkg.sv @@
// Shared types and constants for the Bresenham line stepper unit.
// Holds the request, pixel and command types; no dependencies.
package blsu_pkg;

  localparam int unsigned CoordBits    = 12;
  localparam int unsigned ColorBits    = 16;
  // Error term and diagonal increment are signed, straight increment is unsigned.
  localparam int unsigned ErrBits      = CoordBits + 3;
  localparam int unsigned StraightBits = CoordBits + 2;

  localparam logic ActStart = 1'b0;
  localparam logic ActStep  = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        dist_t;
  typedef logic [ColorBits-1:0]        color_t;

  typedef struct packed {
    logic   action;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t color;
  } line_req_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;
  } pixel_t;

  // Classified request as it travels from the front end to the back end.
  typedef struct packed {
    logic   is_step;
    logic   y_major;
    logic   minor_dir_neg;
    coord_t first_x;
    coord_t first_y;
    coord_t major_end;
    dist_t  dmaj;
    dist_t  dmin;
    color_t color;
  } line_cmd_t;

endpackage

@@ rtl/blsu_front.sv @@
// Front end of the line stepper: classifies a request and sets up a new line.
// Uses blsu_pkg.
module blsu_front (
  input  blsu_pkg::line_req_t req_i,
  output blsu_pkg::line_cmd_t cmd_o
);
  import blsu_pkg::*;

  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits:0]        adx, ady;
  logic                      y_major;
  logic                      swap;
  logic signed [CoordBits:0] raw_min;
  logic                      min_rises;

  always_comb begin
    dx  = {req_i.x_end[CoordBits-1], req_i.x_end} - {req_i.x_start[CoordBits-1], req_i.x_start};
    dy  = {req_i.y_end[CoordBits-1], req_i.y_end} - {req_i.y_start[CoordBits-1], req_i.y_start};
    adx = dx[CoordBits] ? (CoordBits+1)'(-dx) : dx;
    ady = dy[CoordBits] ? (CoordBits+1)'(-dy) : dy;

    // Ties go to the X axis.
    y_major = adx < ady;
    // Order endpoints so the major coordinate rises.
    swap    = y_major ? dy[CoordBits] : dx[CoordBits];
    raw_min = y_major ? dx : dy;
    min_rises = (!swap && !raw_min[CoordBits] && (raw_min != '0)) ||
                (swap && raw_min[CoordBits]);

    cmd_o.is_step       = (req_i.action == ActStep);
    cmd_o.y_major       = y_major;
    cmd_o.minor_dir_neg = !min_rises;
    cmd_o.first_x       = swap ? req_i.x_end : req_i.x_start;
    cmd_o.first_y       = swap ? req_i.y_end : req_i.y_start;
    if (y_major) begin
      cmd_o.major_end = swap ? req_i.y_start : req_i.y_end;
      cmd_o.dmaj      = ady[CoordBits-1:0];
      cmd_o.dmin      = adx[CoordBits-1:0];
    end else begin
      cmd_o.major_end = swap ? req_i.x_start : req_i.x_end;
      cmd_o.dmaj      = adx[CoordBits-1:0];
      cmd_o.dmin      = ady[CoordBits-1:0];
    end
    cmd_o.color = req_i.color;
  end

endmodule

@@ rtl/blsu_queue.sv @@
// Short command queue between front end and back end.
// Uses blsu_pkg for the command type.
module blsu_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  blsu_pkg::line_cmd_t push_cmd_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output blsu_pkg::line_cmd_t head_cmd_o
);
  import blsu_pkg::*;

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  line_cmd_t          entries_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o       = (count_q == CntBits'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/blsu_back.sv @@
// Back end of the line stepper: holds the line state, steps it, and drives
// the pixel output register. Uses blsu_pkg.
module blsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  blsu_pkg::line_cmd_t head_cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blsu_pkg::pixel_t    out_pixel_o
);
  import blsu_pkg::*;

  logic                      active_q, active_d;
  logic                      out_valid_q, out_valid_d;
  pixel_t                    pixel_q, pixel_d;
  logic                      y_major_q, y_major_d;
  logic                      dir_neg_q, dir_neg_d;
  coord_t                    cur_x_q, cur_x_d;
  coord_t                    cur_y_q, cur_y_d;
  coord_t                    major_end_q, major_end_d;
  logic [ErrBits-1:0]        err_q, err_d;
  logic [ErrBits-1:0]        incr_diag_q, incr_diag_d;
  logic [StraightBits-1:0]   incr_straight_q, incr_straight_d;
  color_t                    color_q, color_d;

  logic   out_free;
  logic   do_start, do_step;
  coord_t maj_next, min_next;
  logic   step_last, start_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign do_start = head_valid_i && !head_cmd_i.is_step && out_free;
  assign do_step  = head_valid_i && head_cmd_i.is_step && active_q && out_free;
  // Drop a step that arrives with no line in progress.
  assign pop_o    = do_start || do_step ||
                    (head_valid_i && head_cmd_i.is_step && !active_q);

  always_comb begin
    active_d        = active_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    pixel_d         = pixel_q;
    y_major_d       = y_major_q;
    dir_neg_d       = dir_neg_q;
    cur_x_d         = cur_x_q;
    cur_y_d         = cur_y_q;
    major_end_d     = major_end_q;
    err_d           = err_q;
    incr_diag_d     = incr_diag_q;
    incr_straight_d = incr_straight_q;
    color_d         = color_q;

    maj_next   = (y_major_q ? cur_y_q : cur_x_q) + CoordBits'(1);
    min_next   = (y_major_q ? cur_x_q : cur_y_q);
    if (!err_q[ErrBits-1]) begin
      min_next = dir_neg_q ? min_next - CoordBits'(1) : min_next + CoordBits'(1);
    end
    step_last  = (maj_next >= major_end_q);
    start_last = (head_cmd_i.dmaj == '0);

    if (do_start) begin
      y_major_d       = head_cmd_i.y_major;
      dir_neg_d       = head_cmd_i.minor_dir_neg;
      cur_x_d         = head_cmd_i.first_x;
      cur_y_d         = head_cmd_i.first_y;
      major_end_d     = head_cmd_i.major_end;
      color_d         = head_cmd_i.color;
      err_d           = {2'b00, head_cmd_i.dmin, 1'b0} - {3'b000, head_cmd_i.dmaj};
      incr_diag_d     = {2'b00, head_cmd_i.dmin, 1'b0} - {2'b00, head_cmd_i.dmaj, 1'b0};
      incr_straight_d = {1'b0, head_cmd_i.dmin, 1'b0};
      active_d        = !start_last;
      out_valid_d     = 1'b1;
      pixel_d         = '{pixel_x:     head_cmd_i.first_x,
                          pixel_y:     head_cmd_i.first_y,
                          pixel_color: head_cmd_i.color,
                          last_pixel:  start_last};
    end else if (do_step) begin
      if (y_major_q) begin
        cur_y_d = maj_next;
        cur_x_d = min_next;
      end else begin
        cur_x_d = maj_next;
        cur_y_d = min_next;
      end
      err_d       = err_q[ErrBits-1] ? err_q + {1'b0, incr_straight_q} : err_q + incr_diag_q;
      active_d    = !step_last;
      out_valid_d = 1'b1;
      pixel_d     = '{pixel_x:     y_major_q ? min_next : maj_next,
                      pixel_y:     y_major_q ? maj_next : min_next,
                      pixel_color: color_q,
                      last_pixel:  step_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q         <= pixel_d;
    y_major_q       <= y_major_d;
    dir_neg_q       <= dir_neg_d;
    cur_x_q         <= cur_x_d;
    cur_y_q         <= cur_y_d;
    major_end_q     <= major_end_d;
    err_q           <= err_d;
    incr_diag_q     <= incr_diag_d;
    incr_straight_q <= incr_straight_d;
    color_q         <= color_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = pixel_q;

endmodule

@@ rtl/bresenham_line_stepper_unit.sv @@
// Bresenham line stepper: a start request loads two endpoints and a color and
// emits the first pixel; each step request emits the next pixel of the line,
// the final one flagged last_pixel. A step with no line in progress yields no
// pixel. Requests enter a queue at the accept edge; the back end takes the
// head once the output register is free and loads its pixel into that
// register, and while the output is not stalled the unit sustains one request
// per clock. The step update (one add on the error term, one compare against
// the major end) sets that rate.
// QueueDepth requests can pile up while the output is stalled before
// in_ready_o drops.
// Uses blsu_pkg, blsu_front, blsu_queue and blsu_back.
module bresenham_line_stepper_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  blsu_pkg::line_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output blsu_pkg::pixel_t    out_pixel_o
);
  import blsu_pkg::*;

  line_cmd_t front_cmd;
  line_cmd_t head_cmd;
  logic      queue_full;
  logic      head_valid;
  logic      pop;
  logic      push;

  // Classify the request and work out the line setup before queuing.
  blsu_front u_front (
    .req_i (in_req_i),
    .cmd_o (front_cmd)
  );

  // Accept whenever the queue has room; a stalled output blocks intake only once it fills.
  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  blsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (front_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // Advance the line state and hold each pixel until the consumer takes it.
  blsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pixel_o  (out_pixel_o)
  );

endmodule

@@ sim/tb.sv @@
// Testbench for bresenham_line_stepper_unit: drives start and step requests,
// predicts every pixel in-line and checks each one as it leaves the unit.
// Depends on blsu_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb;
  import blsu_pkg::*;

  localparam int NumRandom = 1820;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  line_req_t in_req      = '0;
  logic      out_ready   = 1'b0;
  logic      in_ready;
  logic      out_valid;
  pixel_t    out_pixel;

  line_req_t pending_reqs[$];   // requests waiting to be offered to the unit
  pixel_t    pix_expected[$];   // pixels predicted but not yet seen
  int        fail_cnt  = 0;
  int        cyc       = 0;
  int        gap_left  = 0;
  int        stall_left = 0;

  // Predicted line state, updated at each accepted request.
  bit        ln_active;
  bit        ln_y_major;
  bit        ln_minor_neg;
  int        ln_x;
  int        ln_y;
  int        ln_major_end;
  int        ln_err;
  int        ln_inc_diag;
  int        ln_inc_straight;
  color_t    ln_color;

  bresenham_line_stepper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_pixel_o (out_pixel)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Random content in every field; step requests carry junk that must be ignored.
  function automatic line_req_t rand_req(logic act);
    line_req_t r;
    r.action  = act;
    r.x_start = coord_t'($urandom);
    r.y_start = coord_t'($urandom);
    r.x_end   = coord_t'($urandom);
    r.y_end   = coord_t'($urandom);
    r.color   = color_t'($urandom);
    return r;
  endfunction

  function automatic void push_start(int x1, int y1, int x2, int y2, color_t c);
    line_req_t r;
    r = rand_req(ActStart);
    r.x_start = coord_t'(x1);
    r.y_start = coord_t'(y1);
    r.x_end   = coord_t'(x2);
    r.y_end   = coord_t'(y2);
    r.color   = c;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_steps(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(ActStep));
  endfunction

  // Work out the pixel an accepted request yields, if any, and queue it.
  function automatic void predict_pixel(line_req_t r);
    int     x1, y1, x2, y2, maj1, maj2, min1, min2, dmaj, dmin, tmp;
    bit     is_last;
    pixel_t p;
    if (r.action == ActStart) begin
      x1 = int'(r.x_start);
      y1 = int'(r.y_start);
      x2 = int'(r.x_end);
      y2 = int'(r.y_end);
      // Ties between |dx| and |dy| go to the X axis.
      ln_y_major = iabs(x2 - x1) < iabs(y2 - y1);
      if (ln_y_major) begin
        maj1 = y1; maj2 = y2; min1 = x1; min2 = x2;
      end else begin
        maj1 = x1; maj2 = x2; min1 = y1; min2 = y2;
      end
      // Order the endpoints so the major coordinate rises.
      if (maj1 > maj2) begin
        tmp = maj1; maj1 = maj2; maj2 = tmp;
        tmp = min1; min1 = min2; min2 = tmp;
      end
      ln_minor_neg    = !(min2 > min1);
      dmaj            = maj2 - maj1;
      dmin            = iabs(min2 - min1);
      ln_err          = 2 * dmin - dmaj;
      ln_inc_diag     = 2 * (dmin - dmaj);
      ln_inc_straight = 2 * dmin;
      ln_major_end    = maj2;
      ln_color        = r.color;
      if (ln_y_major) begin
        ln_y = maj1; ln_x = min1;
      end else begin
        ln_x = maj1; ln_y = min1;
      end
      // A zero-length line is done with its first pixel.
      is_last   = (maj1 == maj2);
      ln_active = !is_last;
    end else begin
      // Drop steps with no line in progress.
      if (!ln_active) return;
      if (ln_y_major) begin
        ln_y++;
        if (ln_err >= 0) ln_x += ln_minor_neg ? -1 : 1;
        is_last = ln_y >= ln_major_end;
      end else begin
        ln_x++;
        if (ln_err >= 0) ln_y += ln_minor_neg ? -1 : 1;
        is_last = ln_x >= ln_major_end;
      end
      ln_err += (ln_err >= 0) ? ln_inc_diag : ln_inc_straight;
      if (is_last) ln_active = 1'b0;
    end
    p.pixel_x     = coord_t'(ln_x);
    p.pixel_y     = coord_t'(ln_y);
    p.pixel_color = ln_color;
    p.last_pixel  = is_last;
    pix_expected.push_back(p);
  endfunction

  function automatic void check_pixel(pixel_t got);
    pixel_t want;
    if (pix_expected.size() == 0) begin
      $error("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y);
      fail_cnt++;
      return;
    end
    want = pix_expected.pop_front();
    if (got.pixel_x !== want.pixel_x) begin
      $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
      fail_cnt++;
    end
    if (got.pixel_y !== want.pixel_y) begin
      $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
      fail_cnt++;
    end
    if (got.pixel_color !== want.pixel_color) begin
      $error("pixel_color: expected %h, got %h", want.pixel_color, got.pixel_color);
      fail_cnt++;
    end
    if (got.last_pixel !== want.last_pixel) begin
      $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
      fail_cnt++;
    end
  endfunction

  // Idling is allowed in the first three quarters of each window of the cycle
  // counter and never once the queue of pending requests is nearly drained.
  function automatic bit idle_allowed();
    return (pending_reqs.size() > 300) && ((cyc % 512) < 384);
  endfunction

  // Driver: predict at the accept edge, then offer the next request unless a
  // gap is running. Hold valid and payload while the unit is not ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (in_valid && in_ready) predict_pixel(in_req);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
          gap_left <= $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted pixel and stall the output in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_pixel(out_pixel);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed cases first, then mostly whole lines with random content.
  initial begin
    int n_items, kind, sz, x1, y1, x2, y2, dmaj, n_steps, tail;

    ln_active       = 1'b0;
    ln_y_major      = 1'b0;
    ln_minor_neg    = 1'b0;
    ln_x            = 0;
    ln_y            = 0;
    ln_major_end    = 0;
    ln_err          = 0;
    ln_inc_diag     = 0;
    ln_inc_straight = 0;
    ln_color        = '0;

    // Step right out of reset: nothing to draw.
    push_steps(1);
    // Full-range diagonal, a tie that goes to X.
    push_start(-2048, -2048, 2047, 2047, 16'hFFFF);
    push_steps(3);
    // Restart mid-line with reversed endpoints that must be swapped.
    push_start(2047, 2047, -2048, -2048, 16'h0000);
    push_steps(2);
    // Zero-length line, then a step that must be ignored.
    push_start(5, -7, 5, -7, 16'h1234);
    push_steps(1);
    // Steep line on Y with a falling minor axis, stepped one past its end.
    push_start(0, 0, 2, -5, 16'hA5A5);
    push_steps(6);
    // Equal minor coordinates, major axis falling.
    push_start(100, 3, 96, 3, 16'h5A5A);
    push_steps(4);

    // One line across the whole X range, sampled at its start.
    x1 = -2048; x2 = 2047;
    y1 = rand_coord(); y2 = rand_coord();
    push_start(x1, y1, x2, y2, color_t'($urandom));
    push_steps(40);
    // Reversed line that ends on the top edge, stepped to its end.
    push_start(2047, 2047, 1980, 2000, color_t'($urandom));
    push_steps(67);

    n_items = 0;
    while (n_items < NumRandom) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // Noise: a lone request of either kind.
        pending_reqs.push_back(rand_req(logic'($urandom_range(0, 1))));
        n_items++;
      end else begin
        sz = (kind < 15) ? 15 : (kind < 19) ? 127 : 4095;
        x1 = rand_coord();
        y1 = rand_coord();
        x2 = clamp_coord(x1 + int'($urandom_range(0, 2 * sz)) - sz);
        y2 = clamp_coord(y1 + int'($urandom_range(0, 2 * sz)) - sz);
        dmaj = (iabs(x2 - x1) > iabs(y2 - y1)) ? iabs(x2 - x1) : iabs(y2 - y1);
        push_start(x1, y1, x2, y2, color_t'($urandom));
        tail = $urandom_range(0, 7);
        if (sz == 4095) begin
          // Wide lines are only sampled, then dropped by the next start.
          n_steps = $urandom_range(0, 20);
          if (n_steps > dmaj) n_steps = dmaj;
        end else if (tail == 0) begin
          n_steps = $urandom_range(0, dmaj);
        end else begin
          n_steps = dmaj;
        end
        push_steps(n_steps);
        n_items += 1 + n_steps;
        // Run past the end now and then; those steps yield nothing.
        if (tail == 1 && n_steps == dmaj) push_steps($urandom_range(1, 3));
      end
    end

    // Drain: all requests accepted and every predicted pixel seen.
    forever begin
      @(negedge clk_i);
      if (rst_ni && pending_reqs.size() == 0 && !in_valid && pix_expected.size() == 0)
        break;
    end
    // Give trailing ignored steps time to show any stray pixel.
    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
